[design/assert_macros.svh]
// assertion macros used by the design files (bdd_model_count includes them)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[design/bmc_pkg.sv]
// types, constants and helper functions of the bdd model counter
package bmc_pkg;

  localparam int unsigned NODE_SLOTS = 4096;
  localparam int unsigned SLOT_W     = $clog2(NODE_SLOTS);
  localparam int unsigned ID_W       = 12;
  localparam int unsigned VAR_W      = 10;
  localparam int unsigned LVL_W      = VAR_W + 1;
  localparam int unsigned COUNT_W    = 63;
  localparam int unsigned SH_W       = $clog2(COUNT_W + 1);

  localparam logic [VAR_W-1:0]   MAX_VARS      = 10'd1023;
  localparam logic [VAR_W-1:0]   NUM_VARS_RST  = 10'd1023;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [ID_W-1:0]    ID_FALSE      = 12'd0;
  localparam logic [ID_W-1:0]    ID_TRUE       = 12'd1;

  typedef struct packed {
    logic [ID_W-1:0]  node_id;
    logic [VAR_W-1:0] var_index;
    logic [ID_W-1:0]  low_child;
    logic [ID_W-1:0]  high_child;
  } bmc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] node_count;
    logic [COUNT_W-1:0] root_count;
    logic               saturated;
  } bmc_out_t;

  // one node table entry
  typedef struct packed {
    logic [VAR_W-1:0]   level;
    logic [COUNT_W-1:0] count;
  } bmc_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr_lo;
    logic [SLOT_W-1:0] addr_hi;
  } bmc_rd_req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    bmc_entry_t        data;
  } bmc_wr_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] value;
    logic               sat;
  } bmc_shift_t;

  // true for an id that names a stored node, not a terminal
  function automatic logic is_node(input logic [ID_W-1:0] id);
    return (id != ID_FALSE) && (id != ID_TRUE);
  endfunction

  // levels skipped between a node and its child, zero if the child is not below
  function automatic logic [LVL_W-1:0] level_gap(input logic [LVL_W-1:0] lvl,
                                                 input logic [VAR_W-1:0] vidx);
    logic [LVL_W-1:0] v;
    v = {1'b0, vidx};
    if (lvl > v) begin
      return lvl - v - LVL_W'(1);
    end
    return '0;
  endfunction

  // left shift with saturation at all ones; a zero value never saturates
  function automatic bmc_shift_t sat_shl(input logic [COUNT_W-1:0] x,
                                         input logic [LVL_W-1:0]   amt);
    bmc_shift_t         r;
    logic [SH_W-1:0]    rsh;
    logic [COUNT_W-1:0] lost;
    r.value = x;
    r.sat   = 1'b0;
    rsh     = '0;
    lost    = '0;
    if ((amt != '0) && (x != '0)) begin
      if (amt >= LVL_W'(COUNT_W)) begin
        r.value = COUNT_MAX;
        r.sat   = 1'b1;
      end else begin
        rsh  = SH_W'(COUNT_W) - amt[SH_W-1:0];
        lost = x >> rsh;
        if (lost != '0) begin
          r.value = COUNT_MAX;
          r.sat   = 1'b1;
        end else begin
          r.value = x << amt[SH_W-1:0];
        end
      end
    end
    return r;
  endfunction

endpackage

[design/bdd_model_count.sv]
// top level of the bdd satisfying-assignment counter
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | input     | in_valid / in_ready   | bmc_in_t: node id, var, low, high
//   out     | output    | out_valid / out_ready | bmc_out_t: node count, root count, sat
//   cfg     | input     | cfg_valid / cfg_ready | num_vars (10 bits), always ready
//
// one item enters per cycle unless stalled; it passes the read, add and root-shift stages
// a node whose child is the node accepted just before it waits: that child is still
//   in the read stage with no count yet; later children come from the memory or are
//   forwarded from the root-shift stage register
// the node table is a 4096-entry memory with two read ports; it needs no clearing pass,
//   terminals never touch it, so the block takes items right after reset
// rst_n is synchronous, active low; it clears the valid bits and num_vars (to 1023)
// a stalled output freezes the pipeline only once the root-shift stage is full too
module bdd_model_count (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmc_pkg::VAR_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bmc_pkg::bmc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bmc_pkg::bmc_out_t              out_data
);

`include "assert_macros.svh"

  // configuration
  logic [bmc_pkg::VAR_W-1:0] num_vars_r;
  logic [bmc_pkg::VAR_W-1:0] nv_eff;
  logic [bmc_pkg::LVL_W-1:0] term_lvl;

  // read stage: memory data arrives here
  logic                       s1_v_r;
  logic [bmc_pkg::ID_W-1:0]   s1_id_r;
  logic [bmc_pkg::VAR_W-1:0]  s1_var_r;
  logic [bmc_pkg::ID_W-1:0]   s1_lo_r;
  logic [bmc_pkg::ID_W-1:0]   s1_hi_r;
  logic                       s1_fwd_lo_r;
  logic                       s1_fwd_hi_r;

  // add stage: shifted child counts
  logic                         s2_v_r;
  logic [bmc_pkg::ID_W-1:0]     s2_id_r;
  logic [bmc_pkg::VAR_W-1:0]    s2_var_r;
  logic [bmc_pkg::COUNT_W-1:0]  s2_lo_cnt_r;
  logic [bmc_pkg::COUNT_W-1:0]  s2_hi_cnt_r;
  logic                         s2_sat_r;

  // root-shift stage: node sum, also the forwarding source
  logic                         s3_v_r;
  logic [bmc_pkg::ID_W-1:0]     s3_id_r;
  logic [bmc_pkg::VAR_W-1:0]    s3_var_r;
  logic [bmc_pkg::COUNT_W-1:0]  s3_sum_r;
  logic                         s3_sat_r;

  // output register
  logic              out_valid_r;
  bmc_pkg::bmc_out_t out_data_r;

  // pipeline control
  logic out_free;
  logic advance;
  logic out_load;
  logic accept;
  logic hit_s1_lo;
  logic hit_s1_hi;
  logic hazard;
  logic fwd_lo;
  logic fwd_hi;

  // memory ports
  bmc_pkg::bmc_rd_req_t rd_req;
  bmc_pkg::bmc_wr_req_t wr_req;
  bmc_pkg::bmc_entry_t  rd_lo;
  bmc_pkg::bmc_entry_t  rd_hi;

  // stage datapath
  logic [bmc_pkg::COUNT_W-1:0] lo_cnt;
  logic [bmc_pkg::COUNT_W-1:0] hi_cnt;
  logic [bmc_pkg::LVL_W-1:0]   lo_lvl;
  logic [bmc_pkg::LVL_W-1:0]   hi_lvl;
  bmc_pkg::bmc_shift_t         lo_sh;
  bmc_pkg::bmc_shift_t         hi_sh;
  logic [bmc_pkg::COUNT_W:0]   sum_ext;
  logic [bmc_pkg::COUNT_W-1:0] sum;
  logic                        sum_sat;
  logic [bmc_pkg::LVL_W-1:0]   root_amt;
  bmc_pkg::bmc_shift_t         root_sh;

  // ---------------------------------------------------------------- configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= bmc_pkg::NUM_VARS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_vars_r <= cfg_data;
    end
  end

  // terminals sit one level below the last variable
  assign nv_eff   = (num_vars_r < bmc_pkg::MAX_VARS) ? num_vars_r : bmc_pkg::MAX_VARS;
  assign term_lvl = {1'b0, nv_eff} + bmc_pkg::LVL_W'(1);

  // ---------------------------------------------------------------- control
  // all three stages move together, so the forwarding distance stays fixed
  assign out_free = !out_valid_r || out_ready;
  assign advance  = !s3_v_r || out_free;
  assign out_load = s3_v_r && out_free;

  // child written by the node in the read stage: its sum is not ready yet
  assign hit_s1_lo = s1_v_r && bmc_pkg::is_node(s1_id_r) &&
                     bmc_pkg::is_node(in_data.low_child) &&
                     (in_data.low_child[bmc_pkg::SLOT_W-1:0] == s1_id_r[bmc_pkg::SLOT_W-1:0]);
  assign hit_s1_hi = s1_v_r && bmc_pkg::is_node(s1_id_r) &&
                     bmc_pkg::is_node(in_data.high_child) &&
                     (in_data.high_child[bmc_pkg::SLOT_W-1:0] == s1_id_r[bmc_pkg::SLOT_W-1:0]);
  assign hazard    = hit_s1_lo || hit_s1_hi;

  assign in_ready = advance && !hazard;
  assign accept   = in_valid && in_ready;

  // child written by the node in the add stage: the write lands at the same edge
  // as our read, so take the sum from the root-shift stage while our item is in the read stage
  assign fwd_lo = s2_v_r && bmc_pkg::is_node(s2_id_r) &&
                  bmc_pkg::is_node(in_data.low_child) &&
                  (in_data.low_child[bmc_pkg::SLOT_W-1:0] == s2_id_r[bmc_pkg::SLOT_W-1:0]);
  assign fwd_hi = s2_v_r && bmc_pkg::is_node(s2_id_r) &&
                  bmc_pkg::is_node(in_data.high_child) &&
                  (in_data.high_child[bmc_pkg::SLOT_W-1:0] == s2_id_r[bmc_pkg::SLOT_W-1:0]);

  // ---------------------------------------------------------------- node table
  assign rd_req.en      = accept;
  assign rd_req.addr_lo = in_data.low_child[bmc_pkg::SLOT_W-1:0];
  assign rd_req.addr_hi = in_data.high_child[bmc_pkg::SLOT_W-1:0];

  // terminal node ids are computed but never stored
  assign wr_req.en         = advance && s2_v_r && bmc_pkg::is_node(s2_id_r);
  assign wr_req.addr       = s2_id_r[bmc_pkg::SLOT_W-1:0];
  assign wr_req.data.level = s2_var_r;
  assign wr_req.data.count = sum;

  bmc_node_ram u_ram (
    .clk   (clk),
    .rd    (rd_req),
    .wr    (wr_req),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi)
  );

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // ---------------------------------------------------------------- read stage
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_id_r     <= in_data.node_id;
      s1_var_r    <= in_data.var_index;
      s1_lo_r     <= in_data.low_child;
      s1_hi_r     <= in_data.high_child;
      s1_fwd_lo_r <= fwd_lo;
      s1_fwd_hi_r <= fwd_hi;
    end
  end

  // pick terminal, forwarded or stored child
  always_comb begin
    if (!bmc_pkg::is_node(s1_lo_r)) begin
      lo_cnt = bmc_pkg::COUNT_W'(s1_lo_r == bmc_pkg::ID_TRUE);
      lo_lvl = term_lvl;
    end else if (s1_fwd_lo_r) begin
      lo_cnt = s3_sum_r;
      lo_lvl = {1'b0, s3_var_r};
    end else begin
      lo_cnt = rd_lo.count;
      lo_lvl = {1'b0, rd_lo.level};
    end
    if (!bmc_pkg::is_node(s1_hi_r)) begin
      hi_cnt = bmc_pkg::COUNT_W'(s1_hi_r == bmc_pkg::ID_TRUE);
      hi_lvl = term_lvl;
    end else if (s1_fwd_hi_r) begin
      hi_cnt = s3_sum_r;
      hi_lvl = {1'b0, s3_var_r};
    end else begin
      hi_cnt = rd_hi.count;
      hi_lvl = {1'b0, rd_hi.level};
    end
  end

  // scale each child by the levels it skips
  assign lo_sh = bmc_pkg::sat_shl(lo_cnt, bmc_pkg::level_gap(lo_lvl, s1_var_r));
  assign hi_sh = bmc_pkg::sat_shl(hi_cnt, bmc_pkg::level_gap(hi_lvl, s1_var_r));

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_id_r     <= s1_id_r;
      s2_var_r    <= s1_var_r;
      s2_lo_cnt_r <= lo_sh.value;
      s2_hi_cnt_r <= hi_sh.value;
      s2_sat_r    <= lo_sh.sat || hi_sh.sat;
    end
  end

  // ---------------------------------------------------------------- add stage
  assign sum_ext = {1'b0, s2_lo_cnt_r} + {1'b0, s2_hi_cnt_r};
  assign sum_sat = sum_ext[bmc_pkg::COUNT_W];
  assign sum     = sum_sat ? bmc_pkg::COUNT_MAX : sum_ext[bmc_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_id_r  <= s2_id_r;
      s3_var_r <= s2_var_r;
      s3_sum_r <= sum;
      s3_sat_r <= s2_sat_r || sum_sat;
    end
  end

  // ---------------------------------------------------------------- root shift
  // count as a root: fill in the levels above this node
  assign root_amt = (s3_var_r == '0) ? '0 :
                    {1'b0, s3_var_r - bmc_pkg::VAR_W'(1)};
  assign root_sh  = bmc_pkg::sat_shl(s3_sum_r, root_amt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.node_count <= s3_sum_r;
      out_data_r.root_count <= root_sh.value;
      out_data_r.saturated  <= s3_sat_r || root_sh.sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- assertions
  // a waiting result is never overwritten
  `ASSERT_NEVER(a_out_no_overwrite, clk, rst_n, out_load && out_valid_r && !out_ready)
  // forwarded children always find their producer in the root-shift stage
  `ASSERT_PROP(a_fwd_lo_src, clk, rst_n, (s1_v_r && s1_fwd_lo_r) |-> (s3_v_r && (s3_id_r == s1_lo_r)))
  `ASSERT_PROP(a_fwd_hi_src, clk, rst_n, (s1_v_r && s1_fwd_hi_r) |-> (s3_v_r && (s3_id_r == s1_hi_r)))
  // scaling to the root never shrinks a count
  `ASSERT_PROP(a_root_ge_node, clk, rst_n, out_valid_r |-> (out_data_r.root_count >= out_data_r.node_count))

endmodule

[design/bmc_node_ram.sv]
// node table: count and level per slot, two registered read ports, one write port
module bmc_node_ram (
  input  logic                 clk,
  input  bmc_pkg::bmc_rd_req_t rd,
  input  bmc_pkg::bmc_wr_req_t wr,
  output bmc_pkg::bmc_entry_t  rd_lo,
  output bmc_pkg::bmc_entry_t  rd_hi
);

  bmc_pkg::bmc_entry_t mem_r [bmc_pkg::NODE_SLOTS];
  bmc_pkg::bmc_entry_t rd_lo_r;
  bmc_pkg::bmc_entry_t rd_hi_r;

  // read returns the old entry when a write hits the same slot at the same edge
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_lo_r <= mem_r[rd.addr_lo];
      rd_hi_r <= mem_r[rd.addr_hi];
    end
  end

  assign rd_lo = rd_lo_r;
  assign rd_hi = rd_hi_r;

endmodule
